>>> sv/jbhc_pkg.sv
// Shared types, codes and helpers for the JPEG block Huffman coder.
// No dependencies; imported by every module of the block.
package jbhc_pkg;

    // Request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_CODE  = 2'd2;

    // Table identifiers
    localparam logic [1:0] TBL_LUMA_DC   = 2'd0;
    localparam logic [1:0] TBL_CHROMA_DC = 2'd1;
    localparam logic [1:0] TBL_LUMA_AC   = 2'd2;
    localparam logic [1:0] TBL_CHROMA_AC = 2'd3;

    // Component codes
    localparam logic [1:0] COMP_LUMA    = 2'd0;
    localparam logic [1:0] COMP_INVALID = 2'd3;

    // Special symbols and limits
    localparam logic [7:0] SYM_ZRL   = 8'd240;
    localparam logic [7:0] SYM_EOB   = 8'd0;
    localparam logic [3:0] CAT_LIMIT = 4'd12;
    localparam logic [5:0] RUN_MAX   = 6'd63;
    localparam logic [4:0] LEN_MAX   = 5'd16;

    localparam int BLOCK_COEFS_DEF = 64;
    localparam int TABLE_DEPTH     = 1024;
    localparam int CODE_W          = 27;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;   // request taken this cycle
        logic read;      // fetch table entry
        logic put;       // load output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic need_out;  // offered request yields a result
        logic new_err;   // offered request is a range error
        logic more;      // held item still has words after this one
        logic out_free;  // output register can take a word
    } status_t;

    // Magnitude category: number of significant bits
    function automatic logic [3:0] category(input logic [11:0] mag);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 12; i++)
        begin
            if (mag[i])
            begin
                c = 4'(i + 1);
            end
        end
        return c;
    endfunction

endpackage

>>> sv/jbhc_ctrl.sv
// Sequencer for the JPEG block Huffman coder: accept, table read, emit.
// Depends on jbhc_pkg.
module jbhc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  jbhc_pkg::status_t status,
    output jbhc_pkg::cmd_t    cmd
);
    import jbhc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.need_out)
                    begin
                        state_next = status.new_err ? ST_PUT : ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_PUT;
            end
            ST_PUT:
            begin
                if (status.out_free)
                begin
                    cmd.put    = 1'b1;
                    state_next = status.more ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/jbhc_datapath.sv
// Datapath of the JPEG block Huffman coder: code table memory, DC predictors,
// zero run, category and amplitude logic, output register. Depends on jbhc_pkg.
module jbhc_datapath #(
    parameter int BLOCK_COEFS = jbhc_pkg::BLOCK_COEFS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  jbhc_pkg::cmd_t               cmd,
    output jbhc_pkg::status_t            status,
    input  logic [1:0]                   opcode,
    input  logic [1:0]                   table_select,
    input  logic [7:0]                   load_symbol,
    input  logic [15:0]                  load_code,
    input  logic [4:0]                   load_length,
    input  logic [1:0]                   component,
    input  logic [5:0]                   coef_index,
    input  logic signed [11:0]           coef_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [jbhc_pkg::CODE_W-1:0]  code_bits,
    output logic [4:0]                   code_length,
    output logic                         last_of_run,
    output logic                         range_error
);
    import jbhc_pkg::*;

    localparam logic [5:0] LAST_IDX = 6'(BLOCK_COEFS - 1);

    // Code table: {length, code}
    logic [20:0]     table_mem [TABLE_DEPTH];
    logic [20:0]     rd_data_reg;

    logic [11:0]     pred_reg [3];
    logic [5:0]      run_reg;
    logic [5:0]      run_next;

    // Held item
    logic [1:0]      tbl_reg;
    logic [7:0]      sym_reg;
    logic [3:0]      cat_reg;
    logic [10:0]     amp_reg;
    logic            err_reg;
    logic [1:0]      zrl_reg;

    // Output register
    logic            out_valid_reg;
    logic [CODE_W-1:0] bits_reg;
    logic [4:0]      len_reg;
    logic            last_reg;
    logic            rerr_reg;

    // Request decode
    logic [4:0]      len_sat;
    logic [15:0]     code_masked;
    logic [11:0]     pred_sel;
    logic [12:0]     dc_diff;
    logic [12:0]     sval;
    logic [12:0]     amp_full;
    logic [11:0]     mag;
    logic [3:0]      cat;
    logic            is_dc;
    logic            is_last;
    logic            ac_zero;
    logic            coef_ok;
    logic            err;
    logic [5:0]      run_inc;
    logic [7:0]      sym_new;
    logic [1:0]      tbl_new;
    logic [1:0]      zrl_new;
    logic [3:0]      cat_new;

    // Word assembly
    logic            zrl_active;
    logic [9:0]      rd_addr;
    logic [3:0]      eff_cat;
    logic [10:0]     amp_mask;
    logic [CODE_W-1:0] word_bits;
    logic [4:0]      word_len;

    // Load entry: saturate length, drop bits above it
    always_comb
    begin
        len_sat     = (load_length > LEN_MAX) ? LEN_MAX : load_length;
        code_masked = load_code & 16'((17'd1 << len_sat) - 17'd1);
    end

    // Coefficient decode and status
    always_comb
    begin
        case (component)
            2'd1:    pred_sel = pred_reg[1];
            2'd2:    pred_sel = pred_reg[2];
            default: pred_sel = pred_reg[0];
        endcase
        is_dc    = (coef_index == 6'd0);
        is_last  = (coef_index == LAST_IDX);
        ac_zero  = !is_dc && (coef_value == 12'sd0);
        coef_ok  = (opcode == OP_CODE) && (component != COMP_INVALID)
                   && (coef_index <= LAST_IDX);
        dc_diff  = {coef_value[11], coef_value} - {pred_sel[11], pred_sel};
        sval     = is_dc ? dc_diff : {coef_value[11], coef_value};
        mag      = sval[12] ? 12'(-sval) : sval[11:0];
        cat      = category(mag);
        err      = (cat >= CAT_LIMIT);
        amp_full = sval[12] ? (sval - 13'd1) : sval;
        run_inc  = (run_reg == RUN_MAX) ? RUN_MAX : (run_reg + 6'd1);

        if (is_dc)
        begin
            tbl_new = (component == COMP_LUMA) ? TBL_LUMA_DC : TBL_CHROMA_DC;
        end
        else
        begin
            tbl_new = (component == COMP_LUMA) ? TBL_LUMA_AC : TBL_CHROMA_AC;
        end

        // Symbol, category and ZRL count of the held item
        if (is_dc)
        begin
            sym_new = {4'd0, cat};
            cat_new = cat;
            zrl_new = 2'd0;
        end
        else if (ac_zero)
        begin
            sym_new = SYM_EOB;
            cat_new = 4'd0;
            zrl_new = 2'd0;
        end
        else
        begin
            sym_new = {run_reg[3:0], cat};
            cat_new = cat;
            zrl_new = err ? 2'd0 : run_reg[5:4];
        end

        // Zero run update
        run_next = run_reg;
        if (coef_ok)
        begin
            if (ac_zero && !is_last)
            begin
                run_next = run_inc;
            end
            else
            begin
                run_next = 6'd0;
            end
        end

        status.need_out = coef_ok && (is_dc || !ac_zero || is_last);
        status.new_err  = err;
        status.more     = zrl_active;
        status.out_free = !out_valid_reg || !out_stall;
    end

    // Table memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.capture && (opcode == OP_LOAD))
        begin
            table_mem[{table_select, load_symbol}] <= {len_sat, code_masked};
        end
        if (cmd.read)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // Predictors and zero run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg[0] <= '0;
            pred_reg[1] <= '0;
            pred_reg[2] <= '0;
            run_reg     <= '0;
        end
        else if (cmd.capture)
        begin
            if (opcode == OP_CLEAR)
            begin
                pred_reg[0] <= '0;
                pred_reg[1] <= '0;
                pred_reg[2] <= '0;
            end
            else if (coef_ok && is_dc)
            begin
                case (component)
                    2'd1:    pred_reg[1] <= coef_value;
                    2'd2:    pred_reg[2] <= coef_value;
                    default: pred_reg[0] <= coef_value;
                endcase
            end
            run_reg <= run_next;
        end
    end

    // Held item; ZRL count steps down per emitted ZRL word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zrl_reg <= '0;
            err_reg <= 1'b0;
        end
        else if (cmd.capture && status.need_out)
        begin
            zrl_reg <= zrl_new;
            err_reg <= err;
        end
        else if (cmd.put && zrl_active)
        begin
            zrl_reg <= zrl_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && status.need_out)
        begin
            tbl_reg <= tbl_new;
            sym_reg <= sym_new;
            cat_reg <= cat_new;
            amp_reg <= amp_full[10:0];
        end
    end

    // Word assembly: code then amplitude bits
    always_comb
    begin
        zrl_active  = !err_reg && (zrl_reg != 2'd0);
        rd_addr     = {tbl_reg, zrl_active ? SYM_ZRL : sym_reg};
        eff_cat     = zrl_active ? 4'd0 : cat_reg;
        amp_mask    = 11'((12'd1 << eff_cat) - 12'd1);
        word_bits   = (CODE_W'(rd_data_reg[15:0]) << eff_cat)
                      | CODE_W'(amp_reg & amp_mask);
        word_len    = rd_data_reg[20:16] + 5'(eff_cat);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.put)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            bits_reg <= err_reg ? '0 : word_bits;
            len_reg  <= err_reg ? 5'd0 : word_len;
            last_reg <= !zrl_active;
            rerr_reg <= err_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_bits   = bits_reg;
    assign code_length = len_reg;
    assign last_of_run = last_reg;
    assign range_error = rerr_reg;

endmodule

>>> sv/jpeg_block_huffman_coder.sv
// Top level of the JPEG block Huffman coder: controller plus datapath.
// Depends on jbhc_pkg, jbhc_ctrl and jbhc_datapath.
//
// Baseline JPEG entropy coder for zigzag-ordered coefficients. Each request
// either loads one Huffman table entry, clears the DC predictors, or codes
// one coefficient. Loads, clears, ignored requests and AC zeros that are not
// the block's last coefficient are accepted and produce nothing. A request
// that produces one code word goes through accept, table read and emit into
// the output register; each ZRL word ahead of it adds another table read and
// emit. A range error goes from accept straight to emit, without a read. The
// code table memory registers its read data before the word is assembled,
// hence the table read. The next request is accepted as soon as the
// final word of the previous one sits in the output register. Table entries
// must be loaded before use; their contents are undefined after reset.
module jpeg_block_huffman_coder #(
    parameter int BLOCK_COEFS = jbhc_pkg::BLOCK_COEFS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   opcode,
    input  logic [1:0]                   table_select,
    input  logic [7:0]                   load_symbol,
    input  logic [15:0]                  load_code,
    input  logic [4:0]                   load_length,
    input  logic [1:0]                   component,
    input  logic [5:0]                   coef_index,
    input  logic signed [11:0]           coef_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [jbhc_pkg::CODE_W-1:0]  code_bits,
    output logic [4:0]                   code_length,
    output logic                         last_of_run,
    output logic                         range_error
);
    import jbhc_pkg::*;

    cmd_t    cmd;
    status_t status;

    jbhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    jbhc_datapath #(
        .BLOCK_COEFS (BLOCK_COEFS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .table_select (table_select),
        .load_symbol  (load_symbol),
        .load_code    (load_code),
        .load_length  (load_length),
        .component    (component),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .last_of_run  (last_of_run),
        .range_error  (range_error)
    );

endmodule

>>> sv/jbhc_checker.sv
// Port-level checks for the JPEG block Huffman coder, bound to the top level.
// Depends on jbhc_pkg and jpeg_block_huffman_coder.
module jbhc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [jbhc_pkg::CODE_W-1:0]  code_bits,
    input logic [4:0]                   code_length,
    input logic                         last_of_run,
    input logic                         range_error
);
    import jbhc_pkg::*;

    // Stalled word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Stalled word does not change
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(code_bits) && $stable(code_length)
            && $stable(last_of_run) && $stable(range_error))
        else $error("result changed while stalled");

    // Error word is empty and closes its request
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> code_length == 5'd0 && code_bits == '0
            && last_of_run)
        else $error("malformed range error word");

    // No bits set above the stated length
    a_len_fit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> code_length <= 5'(CODE_W)
            && (code_bits >> code_length) == '0)
        else $error("code bits exceed code length");

endmodule

bind jpeg_block_huffman_coder jbhc_checker u_jbhc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .code_bits   (code_bits),
    .code_length (code_length),
    .last_of_run (last_of_run),
    .range_error (range_error)
);
